// File: hdl/psa_pkg.sv
// shared constants, codes and field widths of the page and superpage allocator
package psa_pkg;

   localparam int PAGE_SLOTS  = 2048;
   localparam int SUPER_SLOTS = 64;
   localparam int ADDR_BITS   = 32;
   localparam int PAGE_SHIFT  = 12;
   localparam int SUPER_SHIFT = 21;

   localparam int PG_NUM_W = ADDR_BITS - PAGE_SHIFT;
   localparam int SP_NUM_W = ADDR_BITS - SUPER_SHIFT;
   localparam int PG_IDX_W = $clog2(PAGE_SLOTS);
   localparam int SP_IDX_W = $clog2(SUPER_SLOTS);
   localparam int PG_CNT_W = $clog2(PAGE_SLOTS + 1);
   localparam int SP_CNT_W = $clog2(SUPER_SLOTS + 1);

   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int SCOUNT_W  = 7;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_BITS  = ADDR_BITS + STATUS_W + PG_CNT_W + SP_CNT_W;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_ALLOC_PAGE  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE_PAGE   = 2'd1;
   localparam logic [OP_W-1:0] OP_ALLOC_SUPER = 2'd2;
   localparam logic [OP_W-1:0] OP_FREE_SUPER  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHYS_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPER_COUNT = 2'd2;

   localparam logic [ADDR_BITS-1:0] LOW_LIMIT_RESET   = 32'h8000_0000;
   localparam logic [ADDR_BITS-1:0] PHYS_TOP_RESET    = 32'h8800_0000;
   localparam logic [SCOUNT_W-1:0]  SUPER_COUNT_RESET = 7'd60;

   typedef struct packed {
      logic [SP_CNT_W-1:0]  superpages_free;
      logic [PG_CNT_W-1:0]  pages_free;
      logic [STATUS_W-1:0]  status;
      logic [ADDR_BITS-1:0] granted_address;
   } rsp_type;

endpackage

// File: hdl/psa_ram.sv
// generic single-port-write, single-port-read ram with registered read
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/page_and_superpage_allocator.sv
// top level: page and superpage free-list allocator with stacks in ram
//
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tuser opcode, tdata address
// rsp     | out | rsp_tvalid/tready    | tdata granted, status, pages, superpages
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// each beat has an accept step (stack ram read issued) and an execute
// step (checks, push write, counter update, result registered)
// a new beat is taken while the previous result still waits on rsp
// execute holds while the result register is full and rsp_tready is low
// reset clears both pool counts and loads the register reset values; no ram clear
module page_and_superpage_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psa_pkg::ADDR_BITS-1:0]     req_tdata,  // address
   input  logic [psa_pkg::OP_W-1:0]          req_tuser,  // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // granted_address, status, pages_free, superpages_free, zero pad
   output logic [psa_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psa_pkg::ADDR_BITS-1:0]     csr_data
);
   import psa_pkg::*;

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_EXEC = 1'b1;

   logic [0:0]           state_ff, state_in;
   logic [OP_W-1:0]      op_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [PG_CNT_W-1:0]  page_count_ff, page_count_in;
   logic [SP_CNT_W-1:0]  super_free_ff, super_free_in;
   logic [ADDR_BITS-1:0] low_limit_ff, phys_top_ff;
   logic [SCOUNT_W-1:0]  super_count_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 accept, done;
   logic                 pg_wr_en, sp_wr_en;
   logic [PG_NUM_W-1:0]  pg_rd_data;
   logic [SP_NUM_W-1:0]  sp_rd_data;
   logic [ADDR_BITS:0]   span;
   logic [ADDR_BITS-1:0] base;
   logic [SP_CNT_W-1:0]  super_cap;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !reset && (state_ff == S_IDLE);
   assign done       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = !reset;

   psa_ram #(.WIDTH(PG_NUM_W), .DEPTH(PAGE_SLOTS)) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_wr_en),
      .wr_addr (page_count_ff[PG_IDX_W-1:0]),
      .wr_data (addr_ff[ADDR_BITS-1:PAGE_SHIFT]),
      .rd_en   (accept),
      .rd_addr (PG_IDX_W'(page_count_ff - 1'b1)),
      .rd_data (pg_rd_data)
   );

   psa_ram #(.WIDTH(SP_NUM_W), .DEPTH(SUPER_SLOTS)) u_super_ram (
      .clock   (clock),
      .wr_en   (sp_wr_en),
      .wr_addr (super_free_ff[SP_IDX_W-1:0]),
      .wr_data (addr_ff[ADDR_BITS-1:SUPER_SHIFT]),
      .rd_en   (accept),
      .rd_addr (SP_IDX_W'(super_free_ff - 1'b1)),
      .rd_data (sp_rd_data)
   );

   // superpage window below phys_top, floored at zero
   always_comb begin
      span = (ADDR_BITS + 1)'(super_count_ff) << SUPER_SHIFT;
      if (span > {1'b0, phys_top_ff}) begin
         base = '0;
      end else begin
         base = ADDR_BITS'({1'b0, phys_top_ff} - span);
      end
      if (super_count_ff < SCOUNT_W'(SUPER_SLOTS)) begin
         super_cap = SP_CNT_W'(super_count_ff);
      end else begin
         super_cap = SP_CNT_W'(SUPER_SLOTS);
      end
   end

   always_comb begin
      page_count_in               = page_count_ff;
      super_free_in               = super_free_ff;
      pg_wr_en                    = 1'b0;
      sp_wr_en                    = 1'b0;
      rsp_data_in                 = rsp_data_ff;
      rsp_data_in.granted_address = '0;
      rsp_data_in.status          = ST_OK;
      unique case (op_ff)
         OP_ALLOC_PAGE: begin
            if (page_count_ff == '0) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               page_count_in = page_count_ff - 1'b1;
               rsp_data_in.granted_address = {pg_rd_data, {PAGE_SHIFT{1'b0}}};
            end
         end
         OP_FREE_PAGE: begin
            if (|addr_ff[PAGE_SHIFT-1:0]) begin
               rsp_data_in.status = ST_MISALIGNED;
            end else if (addr_ff < low_limit_ff || addr_ff >= phys_top_ff) begin
               rsp_data_in.status = ST_RANGE;
            end else if (page_count_ff >= PG_CNT_W'(PAGE_SLOTS)) begin
               rsp_data_in.status = ST_OVERFLOW;
            end else begin
               pg_wr_en      = done;
               page_count_in = page_count_ff + 1'b1;
            end
         end
         OP_ALLOC_SUPER: begin
            if (super_free_ff == '0) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               super_free_in = super_free_ff - 1'b1;
               rsp_data_in.granted_address = {sp_rd_data, {SUPER_SHIFT{1'b0}}};
            end
         end
         OP_FREE_SUPER: begin
            if (|addr_ff[SUPER_SHIFT-1:0]) begin
               rsp_data_in.status = ST_MISALIGNED;
            end else if (addr_ff < base || addr_ff >= phys_top_ff) begin
               rsp_data_in.status = ST_RANGE;
            end else if (super_free_ff >= super_cap) begin
               rsp_data_in.status = ST_OVERFLOW;
            end else begin
               sp_wr_en      = done;
               super_free_in = super_free_ff + 1'b1;
            end
         end
         default: begin
            rsp_data_in.status = ST_OK;
         end
      endcase
      rsp_data_in.pages_free      = page_count_in;
      rsp_data_in.superpages_free = super_free_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         page_count_ff  <= '0;
         super_free_ff  <= '0;
         low_limit_ff   <= LOW_LIMIT_RESET;
         phys_top_ff    <= PHYS_TOP_RESET;
         super_count_ff <= SUPER_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            page_count_ff <= page_count_in;
            super_free_ff <= super_free_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LOW_LIMIT:   low_limit_ff   <= csr_data;
               CSR_PHYS_TOP:    phys_top_ff    <= csr_data;
               CSR_SUPER_COUNT: super_count_ff <= csr_data[SCOUNT_W-1:0];
               default: begin
                  low_limit_ff <= low_limit_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tuser;
         addr_ff <= req_tdata;
      end
      if (done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   a_page_bound: assert property (@(posedge clock) disable iff (reset)
      page_count_ff <= PG_CNT_W'(PAGE_SLOTS))
      else $error("page pool count above capacity");

   a_super_bound: assert property (@(posedge clock) disable iff (reset)
      super_free_ff <= SP_CNT_W'(SUPER_SLOTS))
      else $error("superpage pool count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted beat did not enter execute");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !done |=> ($stable(page_count_ff) && $stable(super_free_ff)))
      else $error("pool count changed outside execute");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid)
      else $error("finished beat left no result");

endmodule
